// ===== hw/rtl/alkv_pkg.sv =====
// alkv_pkg: shared types and constants for the append-only key/value log.
// Depends on nothing; imported by append_log_key_value_store.
`timescale 1ns / 1ps

package alkv_pkg;

    // Default number of record slots in the page
    localparam int unsigned RecordSlotsDefault = 256;

    localparam int unsigned KeyWidth   = 16;
    localparam int unsigned ValueWidth = 32;
    localparam int unsigned RecWidth   = KeyWidth + ValueWidth;

    // Erased flash reads as all ones
    localparam logic [KeyWidth-1:0]   ErasedKey   = '1;
    localparam logic [ValueWidth-1:0] ErasedValue = '1;

    // Operation codes
    localparam logic OpRead  = 1'b0;
    localparam logic OpWrite = 1'b1;

    // Sequencer states
    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DRAIN,
        S_DONE
    } t_state;

endpackage

// ===== hw/rtl/append_log_key_value_store.sv =====
// append_log_key_value_store: one-page append-only key/value log with a scan unit.
// Depends on alkv_pkg (types, constants).
`timescale 1ns / 1ps

//  channel | signals                                             | direction
//  --------+-----------------------------------------------------+----------
//  in      | i_in_valid, o_in_ready, i_opcode, i_key,            | to block
//          | i_write_value                                       |
//  out     | o_out_valid, i_out_ready, o_read_value,             | from block
//          | o_page_wiped, o_rejected                            |
//
// A write, or a read of an empty page, goes from idle straight to the result
// state. Any other read first scans the filled slots, then drains the last
// read: the single record memory read port visits one filled slot per cycle
// and one comparator checks each record in turn.
// One transaction is in flight at a time; o_in_ready is high only when idle.
// A held result stalls the sequencer in its last state until it is taken.
// Synchronous active-low reset empties the page (fill count to zero); no
// clearing pass is needed since only filled slots are ever read.

module append_log_key_value_store #(
    parameter int unsigned RECORD_SLOTS = alkv_pkg::RecordSlotsDefault
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  logic                              i_opcode,
    input  logic [alkv_pkg::KeyWidth-1:0]     i_key,
    input  logic [alkv_pkg::ValueWidth-1:0]   i_write_value,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic [alkv_pkg::ValueWidth-1:0]   o_read_value,
    output logic                              o_page_wiped,
    output logic                              o_rejected
);

    import alkv_pkg::*;

    localparam int unsigned AW = (RECORD_SLOTS > 1) ? $clog2(RECORD_SLOTS) : 1;
    localparam int unsigned CW = $clog2(RECORD_SLOTS + 1);

    // Record memory: {key, value}
    logic [RecWidth-1:0] r_mem [RECORD_SLOTS];
    logic [RecWidth-1:0] r_rdata;
    logic                mem_we;
    logic [AW-1:0]       mem_waddr;

    t_state                r_state,    n_state;
    logic [CW-1:0]         r_fill,     n_fill;
    logic [AW-1:0]         r_addr,     n_addr;
    logic                  r_scan_vld, n_scan_vld;
    logic [KeyWidth-1:0]   r_key,      n_key;
    logic [ValueWidth-1:0] r_found,    n_found;
    logic                  r_wiped,    n_wiped;
    logic                  r_rej,      n_rej;
    logic                  r_out_vld,  n_out_vld;
    logic [ValueWidth-1:0] r_out_val,  n_out_val;
    logic                  r_out_wip,  n_out_wip;
    logic                  r_out_rej,  n_out_rej;

    logic in_acc;
    logic page_full;
    logic rec_match;
    logic scan_last;
    logic out_free;

    assign o_in_ready   = (r_state == S_IDLE);
    assign in_acc       = i_in_valid && o_in_ready;
    assign page_full    = (r_fill == CW'(RECORD_SLOTS));
    assign rec_match    = r_scan_vld && (r_rdata[RecWidth-1 -: KeyWidth] == r_key);
    assign scan_last    = (CW'(r_addr) == (r_fill - CW'(1)));
    assign out_free     = !r_out_vld || i_out_ready;

    assign o_out_valid  = r_out_vld;
    assign o_read_value = r_out_val;
    assign o_page_wiped = r_out_wip;
    assign o_rejected   = r_out_rej;

    // Memory: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= {i_key, i_write_value};
        end
        r_rdata <= r_mem[r_addr];
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_fill    <= '0;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_fill    <= n_fill;
            r_out_vld <= n_out_vld;
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        r_addr     <= n_addr;
        r_scan_vld <= n_scan_vld;
        r_key      <= n_key;
        r_found    <= n_found;
        r_wiped    <= n_wiped;
        r_rej      <= n_rej;
        r_out_val  <= n_out_val;
        r_out_wip  <= n_out_wip;
        r_out_rej  <= n_out_rej;
    end

    // Sequencer: next state and datapath control
    always_comb begin
        n_state    = r_state;
        n_fill     = r_fill;
        n_addr     = r_addr;
        n_scan_vld = 1'b0;
        n_key      = r_key;
        n_found    = rec_match ? r_rdata[ValueWidth-1:0] : r_found;
        n_wiped    = r_wiped;
        n_rej      = r_rej;
        n_out_vld  = r_out_vld && !i_out_ready;
        n_out_val  = r_out_val;
        n_out_wip  = r_out_wip;
        n_out_rej  = r_out_rej;
        mem_we     = 1'b0;
        mem_waddr  = page_full ? '0 : r_fill[AW-1:0];

        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_key   = i_key;
                    n_addr  = '0;
                    n_wiped = 1'b0;
                    n_rej   = 1'b0;
                    if (i_opcode == OpWrite) begin
                        n_found = '0;
                        n_state = S_DONE;
                        if (i_key == ErasedKey) begin
                            n_rej = 1'b1;
                        end else begin
                            mem_we  = 1'b1;
                            n_wiped = page_full;
                            n_fill  = page_full ? CW'(1) : r_fill + CW'(1);
                        end
                    end else begin
                        n_found = ErasedValue;
                        n_state = (r_fill == '0) ? S_DONE : S_SCAN;
                    end
                end
            end
            // One slot address issued per cycle
            S_SCAN: begin
                n_scan_vld = 1'b1;
                if (scan_last) begin
                    n_state = S_DRAIN;
                end else begin
                    n_addr = r_addr + AW'(1);
                end
            end
            // Last record read comes back and is compared
            S_DRAIN: begin
                n_state = S_DONE;
            end
            S_DONE: begin
                if (out_free) begin
                    n_out_vld = 1'b1;
                    n_out_val = r_found;
                    n_out_wip = r_wiped;
                    n_out_rej = r_rej;
                    n_state   = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

`ifndef ASSERT_OFF
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= CW'(RECORD_SLOTS))
        else $error("fill count beyond page size");

    a_scan_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> (CW'(r_addr) < r_fill))
        else $error("scan address outside filled region");

    a_flags_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_page_wiped && o_rejected))
        else $error("wiped and rejected both set");

    a_write_fills: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && (i_opcode == OpWrite) && (i_key != ErasedKey)) |=> (r_fill != '0))
        else $error("accepted write left page empty");

    a_flags_zero_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_page_wiped || o_rejected)) |-> (o_read_value == '0))
        else $error("write result carries a nonzero value");
`endif

endmodule

// ===== tb/append_log_key_value_store_tb.sv =====
// append_log_key_value_store_tb: self-checking bench for the append-only key/value log.
// Depends on alkv_pkg and append_log_key_value_store; drives random and directed traffic
// through both valid/ready channels and checks every result against a local log mirror.
`timescale 1ns / 1ps

module append_log_key_value_store_tb;

    import alkv_pkg::*;

    localparam int Slots       = RecordSlotsDefault;
    localparam int RandomItems = 400;
    localparam int IdleLimit   = 4000;   // cycles without any transaction
    localparam int HoldCycles  = 600;    // long receiver hold-off
    localparam int SettleWait  = 300;    // longer than a full-page scan

    typedef struct {
        logic                  op;
        logic [KeyWidth-1:0]   key;
        logic [ValueWidth-1:0] wval;
        bit                    drain_first;
    } t_kv_req;

    typedef struct {
        logic [ValueWidth-1:0] rval;
        logic                  wiped;
        logic                  rej;
    } t_kv_resp;

    logic                  i_clk         = 1'b0;
    logic                  i_rst_n       = 1'b0;
    logic                  i_in_valid    = 1'b0;
    logic                  i_opcode      = OpRead;
    logic [KeyWidth-1:0]   i_key         = '0;
    logic [ValueWidth-1:0] i_write_value = '0;
    logic                  i_out_ready   = 1'b0;
    wire                   o_in_ready;
    wire                   o_out_valid;
    wire  [ValueWidth-1:0] o_read_value;
    wire                   o_page_wiped;
    wire                   o_rejected;

    append_log_key_value_store dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_opcode      (i_opcode),
        .i_key         (i_key),
        .i_write_value (i_write_value),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_read_value  (o_read_value),
        .o_page_wiped  (o_page_wiped),
        .o_rejected    (o_rejected)
    );

    // Mirror of the page contents
    logic [KeyWidth-1:0]   log_key [Slots];
    logic [ValueWidth-1:0] log_val [Slots];
    int                    log_fill = 0;

    t_kv_req  pending_q[$];     // items still to be offered
    t_kv_resp lookup_q[$];      // expected results, indexed by transaction number
    int       total_items = 0;
    int       sent_count  = 0;  // updated by the driver with NBAs
    int       rcv_count   = 0;  // updated by the monitor with NBAs
    int       errors      = 0;
    int       stray       = 0;
    int       n_reads = 0, n_writes = 0, n_rejects = 0, n_wipes = 0;

    // Predicted outcome of one transaction; updates the page mirror
    function automatic t_kv_resp apply_to_log(t_kv_req r);
        t_kv_resp o;
        o.rval  = '0;
        o.wiped = 1'b0;
        o.rej   = 1'b0;
        if (r.op == OpRead) begin
            n_reads++;
            o.rval = ErasedValue;
            for (int i = 0; i < log_fill; i++) begin
                if (log_key[i] == r.key) o.rval = log_val[i];
            end
        end else if (r.key == ErasedKey) begin
            n_rejects++;
            o.rej = 1'b1;
        end else begin
            n_writes++;
            if (log_fill >= Slots) begin
                // page full: erase everything, new record lands in slot 0
                for (int i = 0; i < Slots; i++) begin
                    log_key[i] = ErasedKey;
                    log_val[i] = ErasedValue;
                end
                log_fill = 0;
                o.wiped  = 1'b1;
                n_wipes++;
            end
            log_key[log_fill] = r.key;
            log_val[log_fill] = r.wval;
            log_fill++;
        end
        return o;
    endfunction

    function automatic t_kv_req mk_req(logic op, logic [KeyWidth-1:0] k,
                                       logic [ValueWidth-1:0] v, bit d);
        t_kv_req r;
        r.op          = op;
        r.key         = k;
        r.wval        = v;
        r.drain_first = d;
        return r;
    endfunction

    // Idle length: mostly none or short, occasionally long
    function automatic int pick_gap(int long_lo, int long_hi);
        int p;
        p = $urandom_range(0, 99);
        if (p < 60) return 0;
        if (p < 90) return $urandom_range(1, 3);
        return $urandom_range(long_lo, long_hi);
    endfunction

    // Clock
    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Driver: offers queued items on the input channel
    t_kv_req cur_req;
    int      send_gap = 0;
    bit      took;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            took = i_in_valid && o_in_ready;
            if (took) begin
                lookup_q.push_back(apply_to_log(cur_req));
                sent_count <= sent_count + 1;
                // every third block of 64 transactions runs back to back
                send_gap = (((sent_count / 64) % 3) == 1) ? 0 : pick_gap(10, 40);
            end
            if (!i_in_valid || took) begin
                if (send_gap > 0) begin
                    send_gap--;
                    i_in_valid <= 1'b0;
                end else if (pending_q.size() > 0 &&
                             (!pending_q[0].drain_first ||
                              (!took && rcv_count == sent_count))) begin
                    cur_req = pending_q.pop_front();
                    i_in_valid    <= 1'b1;
                    i_opcode      <= cur_req.op;
                    i_key         <= cur_req.key;
                    i_write_value <= cur_req.wval;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: takes results, compares with the oldest outstanding prediction
    int  stall_left = 0;
    int  hold_left  = 0;
    bit  held_once  = 1'b0;
    t_kv_resp want;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            if (o_out_valid && i_out_ready) begin
                if (rcv_count >= sent_count) begin
                    $display({"%0t unexpected result: expected none, ",
                              "got read_value %h wiped %b rejected %b"},
                             $time, o_read_value, o_page_wiped, o_rejected);
                    errors++;
                    stray++;
                end else begin
                    want = lookup_q[rcv_count];
                    if (o_read_value !== want.rval) begin
                        $display("%0t read_value mismatch: expected %h got %h",
                                 $time, want.rval, o_read_value);
                        errors++;
                    end
                    if (o_page_wiped !== want.wiped) begin
                        $display("%0t page_wiped mismatch: expected %b got %b",
                                 $time, want.wiped, o_page_wiped);
                        errors++;
                    end
                    if (o_rejected !== want.rej) begin
                        $display("%0t rejected mismatch: expected %b got %b",
                                 $time, want.rej, o_rejected);
                        errors++;
                    end
                    rcv_count <= rcv_count + 1;
                end
            end
            // ready pattern: one long hold-off, random stalls, quiet stretches
            if (hold_left > 0) begin
                hold_left--;
                i_out_ready <= 1'b0;
            end else if (!held_once && rcv_count == 40) begin
                held_once = 1'b1;
                hold_left = HoldCycles - 1;
                i_out_ready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                i_out_ready <= 1'b0;
            end else if (((rcv_count / 64) % 3) != 2 && $urandom_range(0, 99) < 25) begin
                stall_left = pick_gap(20, 60);
                i_out_ready <= (stall_left == 0);
            end else begin
                i_out_ready <= 1'b1;
            end
        end
    end

    // Watchdog on transaction activity
    int idle_cycles = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
        end
        if (idle_cycles >= IdleLimit) begin
            $display("%0t no transaction for %0d cycles", $time, IdleLimit);
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // Stimulus and end of run
    initial begin
        logic [KeyWidth-1:0]   key_pool[8];
        logic [ValueWidth-1:0] v;
        logic [KeyWidth-1:0]   k;
        int                    p;

        for (int i = 0; i < Slots; i++) begin
            log_key[i] = ErasedKey;
            log_val[i] = ErasedValue;
        end

        // Directed: empty page, key extremes, erased key, overwrite, absent key
        pending_q.push_back(mk_req(OpRead,  16'h0000, 32'hDEAD_BEEF, 1'b0));
        pending_q.push_back(mk_req(OpRead,  ErasedKey, 32'h0000_0000, 1'b0));
        pending_q.push_back(mk_req(OpWrite, 16'h0000, 32'h0000_0000, 1'b0));
        pending_q.push_back(mk_req(OpWrite, 16'hFFFE, 32'hFFFF_FFFF, 1'b0));
        pending_q.push_back(mk_req(OpWrite, ErasedKey, 32'h1234_5678, 1'b0));
        pending_q.push_back(mk_req(OpRead,  16'h0000, 32'hFFFF_FFFF, 1'b0));
        pending_q.push_back(mk_req(OpRead,  16'hFFFE, 32'h0000_0000, 1'b0));
        pending_q.push_back(mk_req(OpRead,  ErasedKey, 32'h5555_5555, 1'b0));
        pending_q.push_back(mk_req(OpWrite, 16'h0000, 32'hA5A5_A5A5, 1'b0));
        pending_q.push_back(mk_req(OpWrite, 16'h8001, 32'h5A5A_5A5A, 1'b0));
        pending_q.push_back(mk_req(OpWrite, 16'h7FFE, 32'h8000_0001, 1'b0));
        pending_q.push_back(mk_req(OpRead,  16'h0000, 32'h0000_0000, 1'b0));
        pending_q.push_back(mk_req(OpRead,  16'h8001, 32'hAAAA_AAAA, 1'b0));
        pending_q.push_back(mk_req(OpRead,  16'h7FFE, 32'h0000_0000, 1'b0));
        pending_q.push_back(mk_req(OpRead,  16'h1234, 32'h0000_0000, 1'b0));
        pending_q.push_back(mk_req(OpWrite, ErasedKey, 32'h0000_0000, 1'b0));
        pending_q.push_back(mk_req(OpRead,  16'hFFFE, 32'h0000_0000, 1'b0));

        // Small working set so that reads mostly hit stored keys
        key_pool[0] = 16'h0000;
        key_pool[1] = 16'hFFFE;
        for (int i = 2; i < 8; i++) key_pool[i] = KeyWidth'($urandom_range(1, 16'hFFFD));

        // Random: write heavy so the page fills and gets erased
        for (int i = 0; i < RandomItems; i++) begin
            p = $urandom_range(0, 99);
            case ($urandom_range(0, 9))
                0:       v = '0;
                1:       v = '1;
                default: v = $urandom();
            endcase
            if (p < 72) begin
                k = key_pool[$urandom_range(0, 7)];
                pending_q.push_back(mk_req(OpWrite, k, v, (i % 97) == 0));
            end else if (p < 76) begin
                k = KeyWidth'($urandom_range(0, 16'hFFFE));
                pending_q.push_back(mk_req(OpWrite, k, v, (i % 97) == 0));
            end else if (p < 79) begin
                pending_q.push_back(mk_req(OpWrite, ErasedKey, v, (i % 97) == 0));
            end else if (p < 94) begin
                k = key_pool[$urandom_range(0, 7)];
                pending_q.push_back(mk_req(OpRead, k, v, (i % 97) == 0));
            end else if (p < 98) begin
                k = KeyWidth'($urandom());
                pending_q.push_back(mk_req(OpRead, k, v, (i % 97) == 0));
            end else begin
                pending_q.push_back(mk_req(OpRead, ErasedKey, v, (i % 97) == 0));
            end
        end
        total_items = pending_q.size();

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        wait (sent_count == total_items);
        wait (rcv_count == sent_count);
        repeat (SettleWait) @(posedge i_clk);

        $display({"Run covered %0d reads, %0d stored writes, ",
                  "%0d erased-key refusals, %0d page erasures"},
                 n_reads, n_writes, n_rejects, n_wipes);
        $display("%0d of %0d results checked, %0d field mismatches or stray results",
                 rcv_count, sent_count, errors);
        if (errors == 0 && stray == 0 && rcv_count == sent_count) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
